// File: design/pp_pkg.sv
// ----------------------------------------------------------------------------
// pp_pkg: shared types for the polygon perimeter block
// Word layouts of the vertex and result channels and of the edge jobs that
// pass from the front end to the back end.
// ----------------------------------------------------------------------------
package pp_pkg;

	// coordinate and result widths fixed by the channel words
	localparam int COORD_BITS  = 24;
	localparam int PERIM_BITS  = 48;
	// edge job queue depth between front and back
	localparam int JOB_Q_DEPTH = 2;

	// input word: one vertex
	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
		logic                         is_last;
	} vertex_t;

	// output word: one perimeter
	typedef struct packed {
		logic [PERIM_BITS-1:0] perimeter;
		logic                  saturated;
	} result_t;

	// edge job: absolute coordinate differences, closing edge ends the polygon
	typedef struct packed {
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		logic                  closing;
	} edge_job_t;

endpackage

// File: design/pp_front.sv
// ----------------------------------------------------------------------------
// pp_front: vertex intake and edge classification
// Takes one vertex word, keeps the first and previous vertex, makes an edge
// job to any previous vertex and, for a last vertex, the closing edge job.
// ----------------------------------------------------------------------------
module pp_front import pp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  vertex_t   vertex,
	output logic      job_push,
	output edge_job_t job,
	input  logic      job_full
);

	logic                         valid_s1;
	vertex_t                      vtx_s1;
	logic                         phase_q;
	logic                         have_first_q;
	logic signed [COORD_BITS-1:0] first_x_q;
	logic signed [COORD_BITS-1:0] first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic signed [COORD_BITS-1:0] ref_x;
	logic signed [COORD_BITS-1:0] ref_y;
	logic                         accept;
	logic                         step_done;

	// absolute difference, always fits the coordinate width unsigned
	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic        [COORD_BITS:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? (~d + 1'b1) : d;
		return m[COORD_BITS-1:0];
	endfunction

	assign full   = valid_s1;
	assign accept = push && !valid_s1;

	// phase 0 measures against the previous vertex, phase 1 closes to the first
	assign ref_x       = phase_q ? first_x_q : prev_x_q;
	assign ref_y       = phase_q ? first_y_q : prev_y_q;
	assign job.dx      = abs_diff(vtx_s1.x_coord, ref_x);
	assign job.dy      = abs_diff(vtx_s1.y_coord, ref_y);
	assign job.closing = phase_q;

	// opening vertex of a polygon makes no edge in phase 0
	assign job_push  = valid_s1 && (phase_q || have_first_q) && !job_full;
	assign step_done = job_push || (valid_s1 && !phase_q && !have_first_q);

	// vertex holding register and classification sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			phase_q      <= 1'b0;
			have_first_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				phase_q  <= 1'b0;
			end else if (step_done) begin
				if (!phase_q) begin
					have_first_q <= 1'b1;
					if (vtx_s1.is_last) begin
						phase_q <= 1'b1;
					end else begin
						valid_s1 <= 1'b0;
					end
				end else begin
					have_first_q <= 1'b0;
					phase_q      <= 1'b0;
					valid_s1     <= 1'b0;
				end
			end
		end
	end

	// vertex payload and polygon corner registers
	always_ff @(posedge clk) begin
		if (accept) begin
			vtx_s1 <= vertex;
		end
		if (step_done && !phase_q) begin
			prev_x_q <= vtx_s1.x_coord;
			prev_y_q <= vtx_s1.y_coord;
			if (!have_first_q) begin
				first_x_q <= vtx_s1.x_coord;
				first_y_q <= vtx_s1.y_coord;
			end
		end
	end

endmodule

// File: design/pp_queue.sv
// ----------------------------------------------------------------------------
// pp_queue: edge job queue
// Short register queue that decouples edge classification from the
// square-root back end.
// ----------------------------------------------------------------------------
module pp_queue import pp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  edge_job_t wr_job,
	output logic      q_full,
	input  logic      rd_en,
	output edge_job_t rd_job,
	output logic      q_empty
);

	localparam int PTR_BITS = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(JOB_Q_DEPTH + 1);

	edge_job_t           slot_q [JOB_Q_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign q_full  = (count_q == CNT_BITS'(JOB_Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_job  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// job storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: design/pp_back.sv
// ----------------------------------------------------------------------------
// pp_back: edge length and perimeter accumulation
// Squares the edge differences, takes a bit-serial integer square root,
// adds the length to a saturating sum and emits the perimeter word on the
// closing edge.
// ----------------------------------------------------------------------------
module pp_back import pp_pkg::*; #(
	parameter int SUM_BITS = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_empty,
	output logic      job_pop,
	input  edge_job_t job,
	output result_t   result,
	output logic      empty,
	input  logic      pop
);

	localparam int SQ_BITS   = 2 * COORD_BITS;
	localparam int RAD_BITS  = 2 * COORD_BITS + 2;
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int REM_BITS  = ROOT_BITS + 2;
	localparam int CNT_BITS  = $clog2(ROOT_BITS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_ADD  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_ACC  = 5'b10000
	} back_state_t;

	back_state_t           state_q;
	logic [COORD_BITS-1:0] dx_q;
	logic [COORD_BITS-1:0] dy_q;
	logic                  closing_q;
	logic [SQ_BITS-1:0]    sqx_q;
	logic [SQ_BITS-1:0]    sqy_q;
	logic [SQ_BITS-1:0]    sqx;
	logic [SQ_BITS-1:0]    sqy;
	logic [RAD_BITS-1:0]   rad_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [ROOT_BITS-1:0]  root_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic                  clamp_q;
	logic                  out_valid_q;
	result_t               out_q;
	logic [REM_BITS-1:0]   rem_shift;
	logic [REM_BITS-1:0]   trial;
	logic                  bit_set;
	logic [SUM_BITS:0]     sum_ext;
	logic [SUM_BITS-1:0]   new_sum;
	logic                  new_clamp;
	logic [63:0]           sum_wide;
	logic                  emit;

	assign job_pop = (state_q == ST_IDLE) && !job_empty;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	// squares of the differences
	assign sqx = dx_q * dx_q;
	assign sqy = dy_q * dy_q;

	// one root bit per cycle: bring down two radicand bits, trial subtract
	assign rem_shift = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign bit_set   = (rem_shift >= trial);

	// saturating accumulate
	assign sum_ext   = {1'b0, sum_q} + (SUM_BITS + 1)'(root_q);
	assign new_sum   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
	assign new_clamp = clamp_q | sum_ext[SUM_BITS];
	assign sum_wide  = 64'(new_sum);
	assign emit      = (state_q == ST_ACC) && closing_q && (!out_valid_q || pop);

	// sequencer, sum and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			clamp_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (!closing_q) begin
						sum_q   <= new_sum;
						clamp_q <= new_clamp;
						state_q <= ST_IDLE;
					end else if (emit) begin
						sum_q       <= '0;
						clamp_q     <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (job_pop) begin
			dx_q      <= job.dx;
			dy_q      <= job.dy;
			closing_q <= job.closing;
		end
		if (state_q == ST_MUL) begin
			sqx_q <= sqx;
			sqy_q <= sqy;
		end
		if (state_q == ST_ADD) begin
			rad_q  <= RAD_BITS'(sqx_q) + RAD_BITS'(sqy_q);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
		end
		if (state_q == ST_ROOT) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= bit_set ? (rem_shift - trial) : rem_shift;
			root_q <= {root_q[ROOT_BITS-2:0], bit_set};
			cnt_q  <= cnt_q - 1'b1;
		end
		if (emit) begin
			out_q.perimeter <= sum_wide[PERIM_BITS-1:0];
			out_q.saturated <= new_clamp;
		end
	end

endmodule

// File: design/polygon_perimeter.sv
// path: the front end turns a vertex word into edge jobs, the edge job queue holds
//   them, and the back end takes each edge through MUL, ADD, ROOT and ACC
// pacing: one edge at a time, set by the 25-step bit-serial square root
//   in the back end; a last vertex also adds the closing edge, a first one no edge
// reset: arst_n clears all control state, empty goes high, no polygon is open
// ----------------------------------------------------------------------------
// polygon_perimeter: Euclidean perimeter of a closed polygon
// Front end classifies vertex words into edge jobs, a short queue feeds the
// square-root back end, which sums edge lengths and emits the perimeter.
// ----------------------------------------------------------------------------
module polygon_perimeter import pp_pkg::*; #(
	parameter int SUM_BITS = 48
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  vertex_t vertex,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic      fe_push;
	edge_job_t fe_job;
	logic      q_full;
	logic      q_empty;
	logic      be_pop;
	edge_job_t q_job;

	// vertex intake
	pp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.vertex   (vertex),
		.job_push (fe_push),
		.job      (fe_job),
		.job_full (q_full)
	);

	// edge job queue
	pp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_push),
		.wr_job  (fe_job),
		.q_full  (q_full),
		.rd_en   (be_pop),
		.rd_job  (q_job),
		.q_empty (q_empty)
	);

	// length and sum
	pp_back #(
		.SUM_BITS (SUM_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (q_empty),
		.job_pop   (be_pop),
		.job       (q_job),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// File: design/pp_checker.sv
// ----------------------------------------------------------------------------
// pp_checker: port-level checks for polygon_perimeter
// Watches the vertex and result channels and checks ordering and content
// of result words against accepted closing vertices.
// ----------------------------------------------------------------------------
module pp_checker import pp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    push,
	input logic    full,
	input vertex_t vertex,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	logic [3:0] pend_q;
	logic       in_last;
	logic       out_take;

	assign in_last  = push && !full && vertex.is_last;
	assign out_take = pop && !empty;

	// closing vertices accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_last && !out_take) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_take && !in_last) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result word changed while waiting");

	// no result word without a closing vertex
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != '0)
		else $error("result word without closing vertex");

	// a clamped sum is never zero
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.saturated |-> result.perimeter != '0)
		else $error("saturated result with zero perimeter");

	// the front end is full in the cycle after it takes a vertex
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("intake free right after accept");

endmodule

bind polygon_perimeter pp_checker u_pp_checker (.*);

// File: test/perimeter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// perimeter_checker: vertex and result word monitor for polygon_perimeter
// Follows every accepted vertex word with its own perimeter arithmetic and
// compares every accepted result word, field by field, with the oldest
// perimeter still owed. Hands the mismatch count and the number of owed
// perimeters to the testbench top.
// ----------------------------------------------------------------------------
module perimeter_checker import pp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  logic    full,
	input  vertex_t vertex,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      mismatches,
	output int      pending
);

	localparam longint unsigned PERIM_MAX = (64'd1 << PERIM_BITS) - 64'd1;

	// polygon tracking state
	logic signed [COORD_BITS-1:0] origin_x, origin_y;
	logic signed [COORD_BITS-1:0] prev_x, prev_y;
	logic                         poly_open;
	longint unsigned              perim_acc;
	logic                         perim_clamped;

	// perimeters owed by the block, oldest first
	result_t pending_perimeters[$];
	result_t owed;
	int      fail_count;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	// floor of the square root, one result bit per step from the top
	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = 26; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= n)
				r = trial;
		end
		return r;
	endfunction

	// truncated euclidean distance in units of 2^-8
	function automatic longint unsigned edge_length(
			input logic signed [COORD_BITS-1:0] ax, input logic signed [COORD_BITS-1:0] ay,
			input logic signed [COORD_BITS-1:0] bx, input logic signed [COORD_BITS-1:0] by);
		longint sx;
		longint sy;
		sx = longint'(ax) - longint'(bx);
		sy = longint'(ay) - longint'(by);
		if (sx < 0)
			sx = -sx;
		if (sy < 0)
			sy = -sy;
		return root_floor(longint'(sx * sx + sy * sy));
	endfunction

	// saturating add into the running perimeter
	task automatic add_edge(input longint unsigned len);
		if (perim_acc > PERIM_MAX || len > PERIM_MAX - perim_acc) begin
			perim_acc     = PERIM_MAX;
			perim_clamped = 1'b1;
		end else begin
			perim_acc = perim_acc + len;
		end
	endtask

	// advance the polygon by one vertex word, queue the perimeter on a closing one
	task automatic track_vertex(input vertex_t v);
		result_t done;
		if (!poly_open) begin
			origin_x      = v.x_coord;
			origin_y      = v.y_coord;
			prev_x        = v.x_coord;
			prev_y        = v.y_coord;
			perim_acc     = 0;
			perim_clamped = 1'b0;
			poly_open     = 1'b1;
		end else begin
			add_edge(edge_length(v.x_coord, v.y_coord, prev_x, prev_y));
			prev_x = v.x_coord;
			prev_y = v.y_coord;
		end
		if (v.is_last) begin
			add_edge(edge_length(v.x_coord, v.y_coord, origin_x, origin_y));
			done.perimeter = perim_acc[PERIM_BITS-1:0];
			done.saturated = perim_clamped;
			pending_perimeters.push_back(done);
			poly_open     = 1'b0;
			perim_acc     = 0;
			perim_clamped = 1'b0;
		end
	endtask

	// watch both channels; results are checked before the new vertex is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x      = '0;
			origin_y      = '0;
			prev_x        = '0;
			prev_y        = '0;
			poly_open     = 1'b0;
			perim_acc     = 0;
			perim_clamped = 1'b0;
			fail_count    = 0;
			pending_perimeters.delete();
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (pending_perimeters.size() == 0) begin
					report_mismatch("result word with no perimeter owed",
						64'(result.perimeter), 64'd0);
				end else begin
					owed = pending_perimeters.pop_front();
					if (result.perimeter !== owed.perimeter)
						report_mismatch("perimeter", 64'(result.perimeter),
							64'(owed.perimeter));
					if (result.saturated !== owed.saturated)
						report_mismatch("saturated", 64'(result.saturated),
							64'(owed.saturated));
				end
			end
			if (push && !full)
				track_vertex(vertex);
			pending <= pending_perimeters.size();
		end
	end

endmodule

// File: test/tb_polygon_perimeter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_perimeter: regression for the polygon perimeter block
// Drives a directed set of polygons (single vertices, extreme corners,
// zero-length edges, a 3-4-5 triangle) and then random polygons of mixed
// size and coordinate style, with random idle gaps on both channels.
// Checking is done by perimeter_checker beside the block.
// ----------------------------------------------------------------------------
module tb_polygon_perimeter;
	import pp_pkg::*;

	localparam int RANDOM_VERTICES = 600;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 100;
	localparam int MAX_GAP         = 11;

	localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] C_ONE = COORD_BITS'(256);

	// coordinate styles for random polygons
	typedef enum int {
		STYLE_WIDE,
		STYLE_LOCAL,
		STYLE_CORNER,
		STYLE_STEADY
	} coord_style_t;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	vertex_t vertex;
	logic    empty;
	logic    pop;
	result_t result;
	int      mismatches;
	int      pending;
	bit      steady_send;

	polygon_perimeter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.vertex (vertex),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	perimeter_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.vertex     (vertex),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// offer one vertex word after a random gap and hold it until taken
	task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y, input logic last);
		int gap;
		if ($urandom_range(0, 19) == 0)
			steady_send = !steady_send;
		gap = steady_send ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push           <= 1'b1;
		vertex.x_coord <= x;
		vertex.y_coord <= y;
		vertex.is_last <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// hold off the sender until every owed perimeter has come out
	task automatic wait_for_results();
		push <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	function automatic logic signed [COORD_BITS-1:0] next_coord(input coord_style_t style,
			input logic signed [COORD_BITS-1:0] near);
		case (style)
			STYLE_WIDE:   return COORD_BITS'($urandom());
			STYLE_LOCAL:  return near + COORD_BITS'($urandom_range(0, 1023) - 512);
			STYLE_CORNER: begin
				case ($urandom_range(0, 3))
					0:       return C_MAX;
					1:       return C_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					return near;
				return near + COORD_BITS'($urandom_range(0, 15) - 8);
			end
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		coord_style_t style;
		int           n_verts;
		int           random_sent;
		int           poly_count;
		logic signed [COORD_BITS-1:0] px, py;

		arst_n      = 1'b0;
		push        = 1'b0;
		vertex      = '0;
		steady_send = 1'b0;
		random_sent = 0;
		poly_count  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single vertices give zero
		send_vertex('0, '0, 1'b1);
		send_vertex(C_MAX, C_MIN, 1'b1);
		// longest possible edge, there and back
		send_vertex(C_MIN, C_MIN, 1'b0);
		send_vertex(C_MAX, C_MAX, 1'b1);
		// zero-length edge
		send_vertex(COORD_BITS'(5), COORD_BITS'(-5), 1'b0);
		send_vertex(COORD_BITS'(5), COORD_BITS'(-5), 1'b1);
		// 3-4-5 triangle, exact lengths
		send_vertex('0, '0, 1'b0);
		send_vertex(COORD_BITS'(3 * C_ONE), '0, 1'b0);
		send_vertex('0, COORD_BITS'(4 * C_ONE), 1'b1);
		// rectangle on the coordinate extremes
		send_vertex(C_MIN, '0, 1'b0);
		send_vertex(C_MAX, '0, 1'b0);
		send_vertex(C_MAX, C_MAX, 1'b0);
		send_vertex(C_MIN, C_MAX, 1'b1);
		// sign crossing around the origin
		send_vertex('1, '1, 1'b0);
		send_vertex(COORD_BITS'(1), COORD_BITS'(1), 1'b1);
		// single vertex right after a closed polygon
		send_vertex(C_MAX, C_MAX, 1'b1);
		wait_for_results();

		// random polygons, mostly short, some long
		while (random_sent < RANDOM_VERTICES) begin
			case ($urandom_range(0, 9))
				0:       n_verts = 1;
				8, 9:    n_verts = $urandom_range(7, 16);
				default: n_verts = $urandom_range(2, 6);
			endcase
			style = coord_style_t'($urandom_range(0, 3));
			px    = COORD_BITS'($urandom());
			py    = COORD_BITS'($urandom());
			for (int k = 0; k < n_verts; k++) begin
				if ($urandom_range(0, 7) == 0)
					style = coord_style_t'($urandom_range(0, 3));
				px = next_coord(style, px);
				py = next_coord(style, py);
				send_vertex(px, py, k == n_verts - 1);
				random_sent++;
			end
			poly_count++;
			if (poly_count % 30 == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// result side: random stall before each pop, with stall-free stretches
	initial begin
		int  stall;
		bit  steady_pop;
		pop        = 1'b0;
		steady_pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				steady_pop = !steady_pop;
			stall = steady_pop ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	// watchdog: too many cycles with no word moving on either channel
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stalled = 0;
			else
				stalled++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
